### hw/rtl/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACT_W = 3;
  localparam int ST_W  = 2;

  typedef logic [ACT_W-1:0] op_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_PUSH_BACK  = 3'd1;
  localparam op_t OP_POP_FRONT  = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_LIST_FWD   = 3'd4;
  localparam op_t OP_LIST_BWD   = 3'd5;
  localparam op_t OP_NOP        = 3'd6;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_ENTRY = 2'd3;

  // command queue head as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_ctl_t;

endpackage

### hw/rtl/deq_front.sv
module deq_front import deq_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  op_t                   in_action,
  input  logic [DATA_WIDTH-1:0] in_value,
  output cmd_ctl_t              head_ctl,
  output logic [DATA_WIDTH-1:0] head_value,
  input  logic                  head_pop
);

  op_t                   op_q_r  [2];
  logic [DATA_WIDTH-1:0] val_q_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            fill_r, fill_nxt;
  op_t                   op_cls;
  logic                  push;
  logic                  pop;

  always_comb begin
    if (in_action > OP_LIST_BWD) begin
      op_cls = OP_NOP;
    end else begin
      op_cls = in_action;
    end
  end

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = head_pop && (fill_r != 2'd0);

  assign head_ctl.valid = (fill_r != 2'd0);
  assign head_ctl.op    = op_q_r[rd_ptr_r];
  assign head_value     = val_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q_r[wr_ptr_r]  <= op_cls;
      val_q_r[wr_ptr_r] <= in_value;
    end
  end

endmodule

### hw/rtl/deq_back.sv
module deq_back import deq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_ctl_t              head_ctl,
  input  logic [DATA_WIDTH-1:0] head_value,
  output logic                  head_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output status_t               out_status,
  output logic [DATA_WIDTH-1:0] out_entry,
  output logic [CW-1:0]         out_count,
  output logic                  out_last
);

  localparam int SW = CW + 1;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  logic [DATA_WIDTH-1:0] store_r [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic [AW-1:0] fp_r, fp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          lst_busy_r, lst_busy_nxt;
  logic          lst_fwd_r, lst_fwd_nxt;
  logic [AW-1:0] lst_addr_r, lst_addr_nxt;
  logic [CW-1:0] lst_rem_r, lst_rem_nxt;
  logic          s2_valid_r, s2_valid_nxt;
  logic          s2_last_r;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r;
  logic [DATA_WIDTH-1:0] out_entry_r;
  logic [CW-1:0] out_count_r;
  logic          out_last_r;

  logic          out_free;
  logic          exec;
  logic          iss;
  logic          move;
  logic          full;
  logic          empty;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          start_list;
  status_t       res_status;

  assign out_free = !out_valid_r || out_ready;
  assign exec     = head_ctl.valid && !lst_busy_r && !s2_valid_r && out_free;
  assign iss      = lst_busy_r && (!s2_valid_r || out_free);
  assign move     = s2_valid_r && out_free;
  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_pop = exec;

  always_comb begin
    fp_nxt       = fp_r;
    cnt_nxt      = cnt_r;
    wr_en        = 1'b0;
    wr_addr      = ptr_dec(fp_r);
    start_list   = 1'b0;
    res_status   = ST_DONE;
    lst_fwd_nxt  = lst_fwd_r;
    lst_addr_nxt = lst_addr_r;
    unique case (head_ctl.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          wr_en   = exec;
          cnt_nxt = cnt_r + CW'(1);
          if (head_ctl.op == OP_PUSH_FRONT) begin
            fp_nxt = ptr_dec(fp_r);
          end else begin
            wr_addr = wrap_add(fp_r, cnt_r);
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          if (head_ctl.op == OP_POP_FRONT && cnt_r != CW'(1)) begin
            fp_nxt = ptr_inc(fp_r);
          end
        end
      end
      OP_LIST_FWD, OP_LIST_BWD: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          start_list  = 1'b1;
          lst_fwd_nxt = (head_ctl.op == OP_LIST_FWD);
          if (exec) begin
            lst_addr_nxt = (head_ctl.op == OP_LIST_FWD) ? fp_r
                                                        : wrap_add(fp_r, cnt_r - CW'(1));
          end
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase

    lst_busy_nxt = lst_busy_r;
    lst_rem_nxt  = lst_rem_r;
    if (exec && start_list) begin
      lst_busy_nxt = 1'b1;
      lst_rem_nxt  = cnt_r;
    end else if (iss) begin
      lst_addr_nxt = lst_fwd_r ? ptr_inc(lst_addr_r) : ptr_dec(lst_addr_r);
      lst_rem_nxt  = lst_rem_r - CW'(1);
      lst_busy_nxt = (lst_rem_r != CW'(1));
    end

    if (iss) begin
      s2_valid_nxt = 1'b1;
    end else if (move) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end

    if (move || (exec && !start_list)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r        <= '0;
      cnt_r       <= '0;
      lst_busy_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        fp_r  <= fp_nxt;
        cnt_r <= cnt_nxt;
      end
      lst_busy_r  <= lst_busy_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      lst_fwd_r <= lst_fwd_nxt;
    end
    lst_addr_r <= lst_addr_nxt;
    lst_rem_r  <= lst_rem_nxt;
    if (iss) begin
      s2_last_r <= (lst_rem_r == CW'(1));
    end
    if (move) begin
      out_status_r <= ST_ENTRY;
      out_entry_r  <= rd_data_r;
      out_count_r  <= cnt_r;
      out_last_r   <= s2_last_r;
    end else if (exec && !start_list) begin
      out_status_r <= res_status;
      out_entry_r  <= '0;
      out_count_r  <= cnt_nxt;
      out_last_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= head_value;
    end
    if (iss) begin
      rd_data_r <= store_r[lst_addr_r];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry  = out_entry_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

endmodule

### hw/rtl/double_ended_queue_unit.sv
// Bounded double-ended queue of signed DATA_WIDTH-bit values in a DEPTH-entry ring store.
// Commands (in_tuser) push at the front or back, pop the front or back, or list all
// entries front-to-back or back-to-front; every result carries the count held after
// the command, status in out_tuser (done, empty, full, listed entry) and tlast on the
// final result of the command. Commands enter a two-entry queue, so input is taken
// while the back end works or the output stalls. Push, pop and no-op commands give one
// result each. A listing is started by its command and then reads one entry per cycle,
// while the output does not stall, through the single registered read port of the store;
// each entry passes from the read register to the output register. No clearing pass after
// reset; the store is only read where it was written.
module double_ended_queue_unit import deq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int IW        = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OW        = ((DATA_WIDTH + CW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [IW-1:0] in_tdata,   // value
  input  op_t           in_tuser,   // action
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [OW-1:0] out_tdata,  // entry_value, count
  output status_t       out_tuser,  // status
  output logic          out_tlast
);

  cmd_ctl_t              head_ctl;
  logic [DATA_WIDTH-1:0] head_value;
  logic                  head_pop;
  logic [DATA_WIDTH-1:0] out_entry;
  logic [CW-1:0]         out_count;

  deq_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_value  (in_tdata[DATA_WIDTH-1:0]),
    .head_ctl  (head_ctl),
    .head_value(head_value),
    .head_pop  (head_pop)
  );

  deq_back #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_ctl  (head_ctl),
    .head_value(head_value),
    .head_pop  (head_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_status(out_tuser),
    .out_entry (out_entry),
    .out_count (out_count),
    .out_last  (out_tlast)
  );

  assign out_tdata = OW'({out_count, out_entry});

endmodule

### hw/rtl/deq_checker.sv
module deq_checker import deq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int OW        = ((DATA_WIDTH + CW + 7) / 8) * 8
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [OW-1:0] out_tdata,
  input status_t       out_tuser,
  input logic          out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DATA_WIDTH +: CW] <= CW'(DEPTH))
    else $error("count above depth");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_ENTRY |-> out_tlast && out_tdata[DATA_WIDTH-1:0] == '0)
    else $error("non-entry result not final or nonzero");

  a_list_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == ST_ENTRY && !out_tlast
      |=> !out_tvalid || (out_tuser == ST_ENTRY
      && out_tdata[DATA_WIDTH +: CW] == $past(out_tdata[DATA_WIDTH +: CW])))
    else $error("listing interrupted or count changed");

endmodule

bind double_ended_queue_unit deq_checker #(
  .DEPTH     (DEPTH),
  .DATA_WIDTH(DATA_WIDTH)
) u_deq_checker (.*);
